[design/drp_pkg.sv]
// shared constants, field layout and control types for the drrip replacement engine
// no dependencies; imported by every module of the block except drp_ram
`timescale 1ns / 1ps

package drp_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int RRPV_WIDTH     = 2;
    localparam int SELECTOR_WIDTH = 10;
    localparam int LEADER_SETS    = 64;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = 4;
    localparam int PC_W  = 5;
    localparam int ROW_W = NUM_WAYS * RRPV_WIDTH;

    localparam int RRPV_CEIL  = (1 << RRPV_WIDTH) - 1;
    localparam int PSEL_CEIL  = (1 << SELECTOR_WIDTH) - 1;
    localparam int PSEL_MID   = PSEL_CEIL >> 1;

    localparam int LEADER_STRIDE_RAW = NUM_SETS / (2 * LEADER_SETS);
    localparam int LEADER_STRIDE     = (LEADER_STRIDE_RAW == 0) ? 1 : LEADER_STRIDE_RAW;
    localparam int LEADER_PERIOD     = 2 * LEADER_STRIDE;
    localparam int BIMODAL_PERIOD    = 32;

    // input beat layout
    localparam int SET_LSB   = 0;
    localparam int WAY_LSB   = SET_LSB + SET_W;
    localparam int HIT_BIT   = WAY_LSB + WAY_W;
    localparam int PC_LSB    = HIT_BIT + 1;
    localparam int S_TDATA_W = ((PC_LSB + PC_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WAY_W + 7) / 8) * 8;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef logic [ROW_W-1:0] row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_victim;
        logic out_free;
    } ctrl_status_t;

endpackage

[design/drrip_cache_replacement_top.sv]
// drrip replacement engine: input beats carry victim queries or access updates,
// output beats carry the victim way of each query
// depends on drp_pkg, drp_ctrl and drp_datapath, and through drp_datapath on drp_ram
//
// usage:
//   s_ channel: one beat per request; s_tuser is the op (0 victim query,
//   1 access update). updates produce no output beat.
//   m_ channel: one beat per victim query with the chosen way.
//   each request is accepted together with its set read, then in an execute
//   step the set row is aged or updated and written back to the row
//   memory; the execute step waits on the registered read of that memory.
//   a victim way is on m_tdata in the cycle after the execute step.
//   after reset a clearing pass sets every way of every set to three,
//   during which s_tready stays low; the selector starts at 511.
//   when the receiver stalls, the result waits in the output register;
//   updates are still taken, and the next query holds in its execute
//   step until the output register frees.
`timescale 1ns / 1ps

module drrip_cache_replacement_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // set_index[10:0], way_index[14:11], was_hit[15], pc_low[20:16]
    input  logic [drp_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // victim_way[3:0]
    output logic [drp_pkg::M_TDATA_W-1:0] m_tdata
);

    import drp_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    drp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[design/drp_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module drp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/drp_ctrl.sv]
// controller state machine: clearing sweep, beat acceptance, execute step
// depends on drp_pkg
`timescale 1ns / 1ps

module drp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  drp_pkg::ctrl_status_t status,
    output drp_pkg::ctrl_cmd_t    cmd
);

    import drp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // victim results wait for a free output slot
                if (!status.is_victim || status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[design/drp_datapath.sv]
// datapath: rrpv row memory, aging and victim search, insertion, policy selector
// depends on drp_pkg and drp_ram
`timescale 1ns / 1ps

module drp_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  drp_pkg::ctrl_cmd_t              cmd,
    output drp_pkg::ctrl_status_t           status,
    input  logic [drp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [drp_pkg::M_TDATA_W-1:0]   m_tdata
);

    import drp_pkg::*;

    logic                      op_reg;
    logic [SET_W-1:0]          set_reg;
    logic [WAY_W-1:0]          way_reg;
    logic                      hit_reg;
    logic [PC_W-1:0]           pc_reg;
    logic [SET_W-1:0]          clr_cnt_reg;
    logic [SELECTOR_WIDTH-1:0] sel_reg;
    logic [SELECTOR_WIDTH-1:0] sel_next;
    logic                      m_valid_reg;
    logic [WAY_W-1:0]          victim_reg;

    logic                      ram_wr_en;
    logic [SET_W-1:0]          ram_wr_addr;
    row_t                      ram_wr_data;
    row_t                      row;

    logic [RRPV_WIDTH-1:0]     top;
    logic [RRPV_WIDTH-1:0]     lift;
    logic [RRPV_CEIL:0]        present;
    row_t                      aged_row;
    logic [WAY_W-1:0]          found;
    row_t                      upd_row;
    logic [RRPV_WIDTH-1:0]     ins_val;
    logic                      way_ok;
    logic                      srrip_lead;
    logic                      brrip_lead;
    logic                      srrip_mode;
    logic                      is_victim;
    logic                      do_miss;

    drp_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_SETS)
    ) u_rrpv_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (s_tdata[SET_LSB +: SET_W]),
        .rd_data (row)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= s_tuser;
            set_reg <= s_tdata[SET_LSB +: SET_W];
            way_reg <= s_tdata[WAY_LSB +: WAY_W];
            hit_reg <= s_tdata[HIT_BIT];
            pc_reg  <= s_tdata[PC_LSB +: PC_W];
        end
        if (cmd.exec && is_victim) begin
            victim_reg <= found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            sel_reg     <= SELECTOR_WIDTH'(PSEL_MID);
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec && do_miss) begin
                sel_reg <= sel_next;
            end
            if (cmd.exec && is_victim) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign is_victim = (op_reg == OP_VICTIM);

    // aging: lift every way by the max's gap to the top; victim: lowest way at top
    always_comb begin
        present  = '0;
        top      = '0;
        aged_row = '0;
        found    = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            present[row[w*RRPV_WIDTH +: RRPV_WIDTH]] = 1'b1;
        end
        for (int l = 0; l <= RRPV_CEIL; l++) begin
            if (present[l]) begin
                top = RRPV_WIDTH'(l);
            end
        end
        lift = RRPV_WIDTH'(RRPV_CEIL) - top;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_row[w*RRPV_WIDTH +: RRPV_WIDTH] = row[w*RRPV_WIDTH +: RRPV_WIDTH] + lift;
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (aged_row[w*RRPV_WIDTH +: RRPV_WIDTH] == RRPV_WIDTH'(RRPV_CEIL)) begin
                found = WAY_W'(w);
            end
        end
    end

    // update: promotion on hit, leader training and insertion on miss
    always_comb begin
        way_ok     = ({1'b0, way_reg} < (WAY_W + 1)'(NUM_WAYS));
        do_miss    = !is_victim && way_ok && !hit_reg;
        srrip_lead = ((set_reg % SET_W'(LEADER_PERIOD)) == '0);
        brrip_lead = ((set_reg % SET_W'(LEADER_PERIOD)) == SET_W'(LEADER_STRIDE));
        sel_next   = sel_reg;
        if (srrip_lead) begin
            if (sel_reg != '0) begin
                sel_next = sel_reg - 1'b1;
            end
        end else if (brrip_lead) begin
            if (sel_reg != SELECTOR_WIDTH'(PSEL_CEIL)) begin
                sel_next = sel_reg + 1'b1;
            end
        end
        if (srrip_lead) begin
            srrip_mode = 1'b1;
        end else if (brrip_lead) begin
            srrip_mode = 1'b0;
        end else begin
            srrip_mode = (sel_reg > SELECTOR_WIDTH'(PSEL_MID));
        end
        if (srrip_mode || ((pc_reg & PC_W'(BIMODAL_PERIOD - 1)) == '0)) begin
            ins_val = RRPV_WIDTH'(RRPV_CEIL - 1);
        end else begin
            ins_val = RRPV_WIDTH'(RRPV_CEIL);
        end
        upd_row = row;
        if (hit_reg) begin
            upd_row[way_reg*RRPV_WIDTH +: RRPV_WIDTH] = '0;
        end else begin
            upd_row[way_reg*RRPV_WIDTH +: RRPV_WIDTH] = ins_val;
        end
    end

    always_comb begin
        ram_wr_en   = cmd.clear_wr || (cmd.exec && (is_victim || way_ok));
        ram_wr_addr = cmd.clear_wr ? clr_cnt_reg : set_reg;
        if (cmd.clear_wr) begin
            ram_wr_data = '1;
        end else if (is_victim) begin
            ram_wr_data = aged_row;
        end else begin
            ram_wr_data = upd_row;
        end
    end

    assign status.clear_last = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign status.is_victim  = is_victim;
    assign status.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(victim_reg);

endmodule
